// ----- hw/rtl/prsu_pkg.sv -----
// Shared types, constants and fixed-point helpers of the pairwise ranking update unit.
package prsu_pkg;

    localparam int W_BITS = 32;
    localparam int ACC_W = 48;
    localparam int MUL_W = W_BITS + 1;
    localparam int CFG_W = 25;
    localparam int FRAC = 24;
    localparam int IDX_W = 10;
    localparam int FI_W = 4;

    localparam int DEF_NUM_USERS = 1024;
    localparam int DEF_NUM_ITEMS = 1024;
    localparam int DEF_FACTORS = 16;

    localparam logic [CFG_W-1:0] LEARN_RATE_RST = 25'd167772;
    localparam logic [CFG_W-1:0] FACTOR_REG_RST = 25'd167772;
    localparam logic [CFG_W-1:0] BIAS_REG_RST = 25'd167772;

    localparam logic signed [ACC_W-1:0] ACC_WMAX = 48'sd2147483647;
    localparam logic signed [ACC_W-1:0] ACC_WMIN = -48'sd2147483648;
    localparam logic signed [W_BITS-1:0] WMAX = 32'sh7fffffff;
    localparam logic signed [W_BITS-1:0] WMIN = 32'sh80000000;

    localparam logic [1:0] CFG_LEARN_RATE = 2'd0;
    localparam logic [1:0] CFG_FACTOR_REG = 2'd1;
    localparam logic [1:0] CFG_BIAS_REG = 2'd2;

    localparam logic [1:0] OP_TRAIN = 2'd0;
    localparam logic [1:0] OP_LOAD = 2'd1;
    localparam logic [1:0] OP_PREDICT = 2'd2;
    localparam logic [1:0] OP_READ = 2'd3;

    localparam logic [1:0] SEL_BIAS = 2'd0;
    localparam logic [1:0] SEL_UFAC = 2'd1;
    localparam logic [1:0] SEL_IFAC = 2'd2;

    typedef struct packed {
        logic [1:0]               op;
        logic [IDX_W-1:0]         item_index;
        logic [IDX_W-1:0]         pos_user_index;
        logic [IDX_W-1:0]         neg_user_index;
        logic [1:0]               weight_select;
        logic [IDX_W-1:0]         entry_index;
        logic [FI_W-1:0]          factor_index;
        logic signed [W_BITS-1:0] weight_value;
    } t_cmd;

    typedef struct packed {
        logic signed [W_BITS-1:0] result_value;
        logic                     saturated;
    } t_result;

    typedef struct packed {
        logic ub;
        logic uf;
        logic itm;
    } t_wr_en;

    function automatic logic signed [W_BITS-1:0] sat_w(input logic signed [ACC_W-1:0] v);
        if (v > ACC_WMAX) begin
            return WMAX;
        end else if (v < ACC_WMIN) begin
            return WMIN;
        end
        return v[W_BITS-1:0];
    endfunction

    function automatic logic sat_ovf(input logic signed [ACC_W-1:0] v);
        return (v > ACC_WMAX) || (v < ACC_WMIN);
    endfunction

    // Piecewise linear 1/(1+exp(x)), i.e. the sigmoid of -x, of a Q8.24 input, as a Q1.24 result.
    function automatic logic [CFG_W-1:0] sigmoid_neg(input logic signed [W_BITS-1:0] x);
        logic signed [W_BITS+1:0] z;
        logic signed [W_BITS+1:0] z_neg;
        logic [W_BITS+1:0]        a;
        logic [W_BITS+1:0]        sp;
        z = '0 - (W_BITS+2)'(x);
        z_neg = '0 - z;
        a = z[W_BITS+1] ? z_neg : z;
        if (a >= 34'd83886080) begin
            sp = 34'd16777216;
        end else if (a >= 34'd39845888) begin
            sp = (a >> 5) + 34'd14155776;
        end else if (a >= 34'd16777216) begin
            sp = (a >> 3) + 34'd10485760;
        end else begin
            sp = (a >> 2) + 34'd8388608;
        end
        if (z[W_BITS+1]) begin
            sp = 34'd16777216 - sp;
        end
        return sp[CFG_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/prsu_mac.sv -----
// Shared Q8.24 multiplier: registered magnitude product, truncate and saturate on output.
module prsu_mac (
    input  logic                                 i_clk,
    input  logic signed [prsu_pkg::MUL_W-1:0]    i_a,
    input  logic signed [prsu_pkg::MUL_W-1:0]    i_b,
    output logic signed [prsu_pkg::W_BITS-1:0]   o_q,
    output logic                                 o_sat
);
    import prsu_pkg::*;

    localparam int P_W = 2 * W_BITS;
    localparam int S_W = P_W - FRAC;

    logic signed [MUL_W-1:0] neg_a, neg_b;
    logic [W_BITS-1:0]       mag_a, mag_b;
    logic [P_W-1:0]          r_prod;
    logic                    r_neg;
    logic [S_W-1:0]          shr;
    logic [W_BITS-1:0]       shr_neg;
    logic                    ovf_pos, ovf_neg;

    assign neg_a = '0 - i_a;
    assign neg_b = '0 - i_b;
    assign mag_a = i_a[MUL_W-1] ? neg_a[W_BITS-1:0] : i_a[W_BITS-1:0];
    assign mag_b = i_b[MUL_W-1] ? neg_b[W_BITS-1:0] : i_b[W_BITS-1:0];

    always_ff @(posedge i_clk) begin
        r_prod <= P_W'(mag_a) * P_W'(mag_b);
        r_neg  <= i_a[MUL_W-1] ^ i_b[MUL_W-1];
    end

    assign shr = r_prod[P_W-1:FRAC];
    assign shr_neg = '0 - shr[W_BITS-1:0];
    assign ovf_pos = |shr[S_W-1:W_BITS-1];
    assign ovf_neg = (|shr[S_W-1:W_BITS]) || (shr[W_BITS-1] && (|shr[W_BITS-2:0]));

    always_comb begin
        if (r_neg) begin
            o_q   = ovf_neg ? WMIN : shr_neg;
            o_sat = ovf_neg;
        end else begin
            o_q   = ovf_pos ? WMAX : shr[W_BITS-1:0];
            o_sat = ovf_pos;
        end
    end

endmodule

// ----- hw/rtl/prsu_store.sv -----
// Weight memories: user biases, user factors and item factors, registered reads.
module prsu_store #(
    parameter int NUM_USERS = prsu_pkg::DEF_NUM_USERS,
    parameter int NUM_ITEMS = prsu_pkg::DEF_NUM_ITEMS,
    parameter int FACTORS   = prsu_pkg::DEF_FACTORS,
    parameter int UB_AW     = $clog2(NUM_USERS),
    parameter int UF_AW     = $clog2(NUM_USERS * FACTORS),
    parameter int IF_AW     = (NUM_ITEMS * FACTORS > 1) ? $clog2(NUM_ITEMS * FACTORS) : 1
) (
    input  logic                              i_clk,
    input  prsu_pkg::t_wr_en                  i_wr_en,
    input  logic [prsu_pkg::W_BITS-1:0]       i_wdata,
    input  logic [UB_AW-1:0]                  i_ub_waddr,
    input  logic [UB_AW-1:0]                  i_ub_raddr,
    input  logic [UF_AW-1:0]                  i_uf_waddr,
    input  logic [UF_AW-1:0]                  i_uf_raddr,
    input  logic [IF_AW-1:0]                  i_if_waddr,
    input  logic [IF_AW-1:0]                  i_if_raddr,
    output logic [prsu_pkg::W_BITS-1:0]       o_ub_rdata,
    output logic [prsu_pkg::W_BITS-1:0]       o_uf_rdata,
    output logic [prsu_pkg::W_BITS-1:0]       o_if_rdata
);
    import prsu_pkg::*;

    logic [W_BITS-1:0] m_ub [NUM_USERS];
    logic [W_BITS-1:0] m_uf [NUM_USERS * FACTORS];
    logic [W_BITS-1:0] m_if [NUM_ITEMS * FACTORS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en.ub) begin
            m_ub[i_ub_waddr] <= i_wdata;
        end
        o_ub_rdata <= m_ub[i_ub_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en.uf) begin
            m_uf[i_uf_waddr] <= i_wdata;
        end
        o_uf_rdata <= m_uf[i_uf_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en.itm) begin
            m_if[i_if_waddr] <= i_wdata;
        end
        o_if_rdata <= m_if[i_if_raddr];
    end

endmodule

// ----- hw/rtl/pairwise_ranking_sgd_update_unit.sv -----
// Pairwise ranking SGD update unit: sequencer, one shared multiplier, weight memories.
//
// Channel   Direction  Handshake                 Payload
// command   in         start, busy               i_cmd (t_cmd)
// result    out        o_done (one-cycle strobe) o_result (t_result)
// config    in         i_cfg_valid, o_cfg_ready  i_cfg_index, i_cfg_data
//
// A request is taken at a clock edge with start high and busy low; busy stays
// high until the result strobe has gone by. The single multiplier sets the pace:
// every Q8.24 product of the dot products and of the three vector updates goes
// through it one after another. Reset (i_rst_n low at a clock edge) idles the
// sequencer and restores the step-size and regularization registers; weight
// memories are not cleared. The receiver cannot stall: each result is shown
// for exactly one cycle.
module pairwise_ranking_sgd_update_unit #(
    parameter int NUM_USERS = prsu_pkg::DEF_NUM_USERS,
    parameter int NUM_ITEMS = prsu_pkg::DEF_NUM_ITEMS,
    parameter int FACTORS   = prsu_pkg::DEF_FACTORS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  prsu_pkg::t_cmd                i_cmd,
    output logic                          o_done,
    output prsu_pkg::t_result             o_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [prsu_pkg::CFG_W-1:0]    i_cfg_data
);
    import prsu_pkg::*;

    localparam int UB_AW = $clog2(NUM_USERS);
    localparam int UF_AW = $clog2(NUM_USERS * FACTORS);
    localparam int IF_AW = (NUM_ITEMS * FACTORS > 1) ? $clog2(NUM_ITEMS * FACTORS) : 1;
    localparam int F_W   = (FACTORS > 1) ? $clog2(FACTORS) : 1;
    localparam int ST_N  = 23;

    typedef enum logic [ST_N-1:0] {
        ST_IDLE    = 23'd1 << 0,
        ST_BP      = 23'd1 << 1,
        ST_BN      = 23'd1 << 2,
        ST_ACC     = 23'd1 << 3,
        ST_DOT_RD  = 23'd1 << 4,
        ST_DOT_P   = 23'd1 << 5,
        ST_DOT_ADD = 23'd1 << 6,
        ST_DOT_SUB = 23'd1 << 7,
        ST_DOT_END = 23'd1 << 8,
        ST_SIG     = 23'd1 << 9,
        ST_F_RD    = 23'd1 << 10,
        ST_F_P     = 23'd1 << 11,
        ST_F_N     = 23'd1 << 12,
        ST_F_G     = 23'd1 << 13,
        ST_F_GW    = 23'd1 << 14,
        ST_U0      = 23'd1 << 15,
        ST_U1      = 23'd1 << 16,
        ST_U2      = 23'd1 << 17,
        ST_U3      = 23'd1 << 18,
        ST_LOAD    = 23'd1 << 19,
        ST_RD      = 23'd1 << 20,
        ST_RD_CAP  = 23'd1 << 21,
        ST_DONE    = 23'd1 << 22
    } t_state;

    // Target of the shared update routine (t = g - reg*v; v += lr*t).
    typedef enum logic [2:0] {
        TGT_BIAS_P = 3'd0,
        TGT_BIAS_N = 3'd1,
        TGT_ITEM   = 3'd2,
        TGT_POS    = 3'd3,
        TGT_NEG    = 3'd4
    } t_tgt;

    t_state r_state, n_state;
    t_tgt   r_tgt;
    t_cmd   r_cmd;

    logic [CFG_W-1:0] r_learn_rate, r_factor_reg, r_bias_reg;
    logic [F_W-1:0]   r_f;
    logic [CFG_W-1:0] r_d;

    logic signed [W_BITS-1:0] r_bp, r_bn, r_w, r_p, r_n, r_v, r_t, r_gw, r_dif, r_res;
    logic signed [ACC_W-1:0]  r_g, r_acc;
    logic                     r_sat;

    logic signed [W_BITS-1:0] ub_rd, uf_rd, if_rd;
    logic [W_BITS-1:0]        ub_rdata, uf_rdata, if_rdata;
    logic signed [MUL_W-1:0]  mac_a, mac_b;
    logic signed [W_BITS-1:0] mac_q;
    logic                     mac_sat;

    t_wr_en             wr_en;
    logic [W_BITS-1:0]  wdata;
    logic [UB_AW-1:0]   ub_waddr, ub_raddr;
    logic [UF_AW-1:0]   uf_waddr, uf_raddr;
    logic [IF_AW-1:0]   if_waddr, if_raddr;

    logic signed [ACC_W-1:0] q_ext, t_sum, upd_sum, dif_sum, acc_add, acc_sub;
    logic signed [W_BITS-1:0] upd_val;
    logic [CFG_W-1:0] d_next;
    logic f_last, is_train, same_user;
    logic train_ok, pred_ok, cell_ok, ent_u_ok, ent_i_ok, fi_ok;

    function automatic logic [UF_AW-1:0] uf_addr(input logic [IDX_W-1:0] row,
                                                  input logic [7:0] col);
        return UF_AW'(32'(row) * 32'(FACTORS) + 32'(col));
    endfunction

    function automatic logic [IF_AW-1:0] if_addr(input logic [IDX_W-1:0] row,
                                                  input logic [7:0] col);
        return IF_AW'(32'(row) * 32'(FACTORS) + 32'(col));
    endfunction

    function automatic logic user_ok(input logic [IDX_W-1:0] idx);
        return 32'(idx) < 32'(NUM_USERS);
    endfunction

    function automatic logic item_ok(input logic [IDX_W-1:0] idx);
        return 32'(idx) < 32'(NUM_ITEMS);
    endfunction

    // Request decode, checked on the incoming command at acceptance.
    assign train_ok = item_ok(i_cmd.item_index) && user_ok(i_cmd.pos_user_index)
                      && user_ok(i_cmd.neg_user_index);
    assign pred_ok  = item_ok(i_cmd.item_index) && user_ok(i_cmd.pos_user_index);
    assign ent_u_ok = user_ok(i_cmd.entry_index);
    assign ent_i_ok = item_ok(i_cmd.entry_index);
    assign fi_ok    = 32'(i_cmd.factor_index) < 32'(FACTORS);
    assign cell_ok  = (i_cmd.weight_select == SEL_BIAS && ent_u_ok)
                   || (i_cmd.weight_select == SEL_UFAC && ent_u_ok && fi_ok)
                   || (i_cmd.weight_select == SEL_IFAC && ent_i_ok && fi_ok);

    assign f_last    = (r_f == F_W'(FACTORS - 1));
    assign is_train  = (r_cmd.op == OP_TRAIN);
    assign same_user = (r_cmd.pos_user_index == r_cmd.neg_user_index);

    assign ub_rd = ub_rdata;
    assign uf_rd = uf_rdata;
    assign if_rd = if_rdata;

    // Arithmetic around the shared multiplier output.
    assign q_ext   = ACC_W'(mac_q);
    assign t_sum   = r_g - q_ext;
    assign upd_sum = ACC_W'(r_v) + q_ext;
    assign upd_val = sat_w(upd_sum);
    assign dif_sum = ACC_W'(r_p) - ACC_W'(uf_rd);
    assign acc_add = r_acc + q_ext;
    assign acc_sub = r_acc - q_ext;
    assign d_next  = sigmoid_neg(r_res);

    // Operand select for the multiplier; its product is used one state later.
    always_comb begin
        mac_a = '0;
        mac_b = '0;
        unique case (r_state)
            ST_DOT_P: begin
                mac_a = MUL_W'(uf_rd);
                mac_b = MUL_W'(if_rd);
            end
            ST_DOT_ADD: begin
                mac_a = MUL_W'(uf_rd);
                mac_b = MUL_W'(r_w);
            end
            ST_F_P: begin
                mac_a = MUL_W'(r_d);
                mac_b = MUL_W'(if_rd);
            end
            ST_F_G: begin
                mac_a = MUL_W'(r_d);
                mac_b = MUL_W'(r_dif);
            end
            ST_U0: begin
                mac_a = (r_tgt == TGT_BIAS_P || r_tgt == TGT_BIAS_N)
                        ? MUL_W'(r_bias_reg) : MUL_W'(r_factor_reg);
                mac_b = MUL_W'(r_v);
            end
            ST_U2: begin
                mac_a = MUL_W'(r_learn_rate);
                mac_b = MUL_W'(r_t);
            end
            default: begin
            end
        endcase
    end

    // Memory addressing and writes.
    always_comb begin
        unique case (r_state)
            ST_BN:   ub_raddr = UB_AW'(is_train ? r_cmd.neg_user_index
                                                : r_cmd.pos_user_index);
            ST_RD:   ub_raddr = UB_AW'(r_cmd.entry_index);
            default: ub_raddr = UB_AW'(r_cmd.pos_user_index);
        endcase
        unique case (r_state)
            ST_DOT_P, ST_F_P: uf_raddr = uf_addr(r_cmd.neg_user_index, 8'(r_f));
            ST_RD:   uf_raddr = uf_addr(r_cmd.entry_index, 8'(r_cmd.factor_index));
            default: uf_raddr = uf_addr(r_cmd.pos_user_index, 8'(r_f));
        endcase
        if (r_state == ST_RD) begin
            if_raddr = if_addr(r_cmd.entry_index, 8'(r_cmd.factor_index));
        end else begin
            if_raddr = if_addr(r_cmd.item_index, 8'(r_f));
        end

        wr_en = '0;
        if (r_state == ST_LOAD) begin
            wdata    = r_cmd.weight_value;
            ub_waddr = UB_AW'(r_cmd.entry_index);
            uf_waddr = uf_addr(r_cmd.entry_index, 8'(r_cmd.factor_index));
            if_waddr = if_addr(r_cmd.entry_index, 8'(r_cmd.factor_index));
            wr_en.ub  = (r_cmd.weight_select == SEL_BIAS);
            wr_en.uf  = (r_cmd.weight_select == SEL_UFAC);
            wr_en.itm = (r_cmd.weight_select == SEL_IFAC);
        end else begin
            wdata    = upd_val;
            ub_waddr = UB_AW'((r_tgt == TGT_BIAS_P) ? r_cmd.pos_user_index
                                                     : r_cmd.neg_user_index);
            uf_waddr = (r_tgt == TGT_POS) ? uf_addr(r_cmd.pos_user_index, 8'(r_f))
                                          : uf_addr(r_cmd.neg_user_index, 8'(r_f));
            if_waddr = if_addr(r_cmd.item_index, 8'(r_f));
            if (r_state == ST_U3) begin
                wr_en.ub  = (r_tgt == TGT_BIAS_P) || (r_tgt == TGT_BIAS_N);
                wr_en.uf  = (r_tgt == TGT_POS) || (r_tgt == TGT_NEG);
                wr_en.itm = (r_tgt == TGT_ITEM);
            end
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    unique case (i_cmd.op)
                        OP_TRAIN:   n_state = train_ok ? ST_BP : ST_DONE;
                        OP_PREDICT: n_state = pred_ok ? ST_BP : ST_DONE;
                        OP_LOAD:    n_state = cell_ok ? ST_LOAD : ST_DONE;
                        OP_READ:    n_state = cell_ok ? ST_RD : ST_DONE;
                        default:    n_state = ST_DONE;
                    endcase
                end
            end
            ST_BP:      n_state = ST_BN;
            ST_BN:      n_state = ST_ACC;
            ST_ACC:     n_state = ST_DOT_RD;
            ST_DOT_RD:  n_state = ST_DOT_P;
            ST_DOT_P:   n_state = ST_DOT_ADD;
            ST_DOT_ADD: begin
                if (is_train) begin
                    n_state = ST_DOT_SUB;
                end else begin
                    n_state = f_last ? ST_DOT_END : ST_DOT_RD;
                end
            end
            ST_DOT_SUB: n_state = f_last ? ST_DOT_END : ST_DOT_RD;
            ST_DOT_END: n_state = is_train ? ST_SIG : ST_DONE;
            ST_SIG:     n_state = ST_U0;
            ST_F_RD:    n_state = ST_F_P;
            ST_F_P:     n_state = ST_F_N;
            ST_F_N:     n_state = ST_F_G;
            ST_F_G:     n_state = ST_F_GW;
            ST_F_GW:    n_state = ST_U0;
            ST_U0:      n_state = ST_U1;
            ST_U1:      n_state = ST_U2;
            ST_U2:      n_state = ST_U3;
            ST_U3: begin
                unique case (r_tgt)
                    TGT_BIAS_N: n_state = ST_F_RD;
                    TGT_NEG:    n_state = f_last ? ST_DONE : ST_F_RD;
                    default:    n_state = ST_U0;
                endcase
            end
            ST_LOAD:    n_state = ST_DONE;
            ST_RD:      n_state = ST_RD_CAP;
            ST_RD_CAP:  n_state = ST_DONE;
            ST_DONE:    n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_learn_rate <= LEARN_RATE_RST;
            r_factor_reg <= FACTOR_REG_RST;
            r_bias_reg   <= BIAS_REG_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_LEARN_RATE: r_learn_rate <= i_cfg_data;
                    CFG_FACTOR_REG: r_factor_reg <= i_cfg_data;
                    CFG_BIAS_REG:   r_bias_reg   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    r_cmd <= i_cmd;
                    r_sat <= 1'b0;
                    r_f   <= '0;
                    r_res <= '0;
                end
            end
            ST_BN: r_bp <= ub_rd;
            ST_ACC: begin
                // Start the score with the bias difference, or the user bias.
                r_bn  <= ub_rd;
                r_acc <= is_train ? ACC_W'(r_bp) - ACC_W'(ub_rd) : ACC_W'(r_bp);
            end
            ST_DOT_P: r_w <= if_rd;
            ST_DOT_ADD: begin
                r_acc <= acc_add;
                r_sat <= r_sat | mac_sat;
                if (!is_train) begin
                    r_f <= f_last ? '0 : r_f + 1'b1;
                end
            end
            ST_DOT_SUB: begin
                r_acc <= acc_sub;
                r_sat <= r_sat | mac_sat;
                r_f   <= f_last ? '0 : r_f + 1'b1;
            end
            ST_DOT_END: begin
                r_res <= sat_w(r_acc);
                r_sat <= r_sat | sat_ovf(r_acc);
            end
            ST_SIG: begin
                r_d   <= d_next;
                r_v   <= r_bp;
                r_g   <= ACC_W'(d_next);
                r_tgt <= TGT_BIAS_P;
            end
            ST_F_P: begin
                r_w <= if_rd;
                r_p <= uf_rd;
            end
            ST_F_N: begin
                r_n   <= uf_rd;
                r_gw  <= mac_q;
                r_dif <= sat_w(dif_sum);
                r_sat <= r_sat | mac_sat | sat_ovf(dif_sum);
            end
            ST_F_GW: begin
                r_g   <= q_ext;
                r_sat <= r_sat | mac_sat;
                r_v   <= r_w;
                r_tgt <= TGT_ITEM;
            end
            ST_U1: begin
                r_t   <= sat_w(t_sum);
                r_sat <= r_sat | mac_sat | sat_ovf(t_sum);
            end
            ST_U3: begin
                r_sat <= r_sat | mac_sat | sat_ovf(upd_sum);
                unique case (r_tgt)
                    TGT_BIAS_P: begin
                        // Same user on both sides: take the fresh bias.
                        r_v   <= same_user ? upd_val : r_bn;
                        r_g   <= '0 - ACC_W'(r_d);
                        r_tgt <= TGT_BIAS_N;
                    end
                    TGT_BIAS_N: r_f <= '0;
                    TGT_ITEM: begin
                        r_v   <= r_p;
                        r_g   <= ACC_W'(r_gw);
                        r_tgt <= TGT_POS;
                    end
                    TGT_POS: begin
                        r_v   <= r_n;
                        r_g   <= '0 - ACC_W'(r_gw);
                        r_tgt <= TGT_NEG;
                    end
                    TGT_NEG: r_f <= f_last ? '0 : r_f + 1'b1;
                    default: begin
                    end
                endcase
            end
            ST_LOAD: r_res <= r_cmd.weight_value;
            ST_RD_CAP: begin
                unique case (r_cmd.weight_select)
                    SEL_BIAS: r_res <= ub_rd;
                    SEL_UFAC: r_res <= uf_rd;
                    default:  r_res <= if_rd;
                endcase
            end
            default: begin
            end
        endcase
    end

    prsu_mac u_mac (
        .i_clk (i_clk),
        .i_a   (mac_a),
        .i_b   (mac_b),
        .o_q   (mac_q),
        .o_sat (mac_sat)
    );

    prsu_store #(
        .NUM_USERS (NUM_USERS),
        .NUM_ITEMS (NUM_ITEMS),
        .FACTORS   (FACTORS),
        .UB_AW     (UB_AW),
        .UF_AW     (UF_AW),
        .IF_AW     (IF_AW)
    ) u_store (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wdata    (wdata),
        .i_ub_waddr (ub_waddr),
        .i_ub_raddr (ub_raddr),
        .i_uf_waddr (uf_waddr),
        .i_uf_raddr (uf_raddr),
        .i_if_waddr (if_waddr),
        .i_if_raddr (if_raddr),
        .o_ub_rdata (ub_rdata),
        .o_uf_rdata (uf_rdata),
        .o_if_rdata (if_rdata)
    );

    assign busy        = (r_state != ST_IDLE);
    assign o_done      = (r_state == ST_DONE);
    assign o_cfg_ready = 1'b1;
    assign o_result.result_value = r_res;
    assign o_result.saturated    = r_sat;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(wr_en))
        else $error("more than one memory written in a cycle");

    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|wr_en) |-> (busy && !o_done))
        else $error("memory write outside an active request");

endmodule

// ----- sim/prsu_result_checker.sv -----
// Result checker of the pairwise ranking update unit: predicts every request and compares.
`timescale 1ns / 100ps

module prsu_result_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_busy,
    input  prsu_pkg::t_cmd             i_cmd,
    input  logic                       i_done,
    input  prsu_pkg::t_result          i_result,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [prsu_pkg::CFG_W-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);
    import prsu_pkg::*;

    localparam int NF = DEF_FACTORS;
    localparam longint W_HI = 64'sd2147483647;
    localparam longint W_LO = -64'sd2147483648;
    localparam longint ONE_Q = 64'sd16777216;

    longint user_bias [DEF_NUM_USERS];
    longint user_fac [DEF_NUM_USERS*NF];
    longint item_fac [DEF_NUM_ITEMS*NF];
    longint step_size, fac_decay, bias_decay;
    logic   clamp_seen;

    t_result expected_results[$];

    function automatic longint clamp_w(input longint v);
        if (v > W_HI) begin
            clamp_seen = 1'b1;
            return W_HI;
        end
        if (v < W_LO) begin
            clamp_seen = 1'b1;
            return W_LO;
        end
        return v;
    endfunction

    // Q8.24 product, magnitude truncated, then clamped.
    function automatic longint qmul(input longint a, input longint b);
        logic neg;
        longint unsigned ma, mb, mag;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? longint'(-a) : a;
        mb = (b < 0) ? longint'(-b) : b;
        mag = (ma * mb) >> FRAC;
        if (neg) begin
            if (mag > 64'd2147483648) begin
                clamp_seen = 1'b1;
                return W_LO;
            end
            return -longint'(mag);
        end
        if (mag > 64'd2147483647) begin
            clamp_seen = 1'b1;
            return W_HI;
        end
        return longint'(mag);
    endfunction

    function automatic longint dot_row(input int urow, input int irow);
        longint acc;
        acc = 0;
        for (int f = 0; f < NF; f++) begin
            acc += qmul(user_fac[urow*NF+f], item_fac[irow*NF+f]);
        end
        return acc;
    endfunction

    function automatic longint sig_half(input longint a);
        if (a >= 5 * ONE_Q) return ONE_Q;
        if (a >= 39845888) return (a >>> 5) + 14155776;
        if (a >= ONE_Q) return (a >>> 3) + 10485760;
        return (a >>> 2) + 8388608;
    endfunction

    // Weight 1/(1+exp(x)) is the sigmoid of -x.
    function automatic longint pair_weight(input longint x);
        longint z;
        z = -x;
        if (z < 0) return ONE_Q - sig_half(-z);
        return sig_half(z);
    endfunction

    function automatic t_result predict_op(input t_cmd c);
        t_result r;
        longint res, x, d, t, wf, pf, nf;
        int it, pu, nu, ent, fi;
        it = c.item_index;
        pu = c.pos_user_index;
        nu = c.neg_user_index;
        ent = c.entry_index;
        fi = c.factor_index;
        res = 0;
        clamp_seen = 1'b0;
        case (c.op)
            OP_TRAIN: begin
                x = clamp_w(user_bias[pu] - user_bias[nu] + dot_row(pu, it) - dot_row(nu, it));
                res = x;
                d = pair_weight(x);
                t = clamp_w(d - qmul(bias_decay, user_bias[pu]));
                user_bias[pu] = clamp_w(user_bias[pu] + qmul(step_size, t));
                t = clamp_w(-d - qmul(bias_decay, user_bias[nu]));
                user_bias[nu] = clamp_w(user_bias[nu] + qmul(step_size, t));
                for (int f = 0; f < NF; f++) begin
                    wf = item_fac[it*NF+f];
                    pf = user_fac[pu*NF+f];
                    nf = user_fac[nu*NF+f];
                    t = clamp_w(qmul(d, clamp_w(pf - nf)) - qmul(fac_decay, wf));
                    item_fac[it*NF+f] = clamp_w(wf + qmul(step_size, t));
                    t = clamp_w(qmul(d, wf) - qmul(fac_decay, pf));
                    user_fac[pu*NF+f] = clamp_w(pf + qmul(step_size, t));
                    t = clamp_w(-qmul(d, wf) - qmul(fac_decay, nf));
                    user_fac[nu*NF+f] = clamp_w(nf + qmul(step_size, t));
                end
            end
            OP_PREDICT: begin
                res = clamp_w(user_bias[pu] + dot_row(pu, it));
            end
            default: begin
                // Load stores first, then both ops return the cell.
                if (c.weight_select == SEL_BIAS) begin
                    if (c.op == OP_LOAD) user_bias[ent] = longint'(c.weight_value);
                    res = user_bias[ent];
                end else if (c.weight_select == SEL_UFAC) begin
                    if (c.op == OP_LOAD) user_fac[ent*NF+fi] = longint'(c.weight_value);
                    res = user_fac[ent*NF+fi];
                end else if (c.weight_select == SEL_IFAC) begin
                    if (c.op == OP_LOAD) item_fac[ent*NF+fi] = longint'(c.weight_value);
                    res = item_fac[ent*NF+fi];
                end
            end
        endcase
        r.result_value = res[W_BITS-1:0];
        r.saturated = clamp_seen;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            step_size = longint'(LEARN_RATE_RST);
            fac_decay = longint'(FACTOR_REG_RST);
            bias_decay = longint'(BIAS_REG_RST);
            expected_results.delete();
            o_fail_count = 0;
            o_pending = 0;
        end else begin
            if (i_done) begin
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result %0d/%0b", i_result.result_value,
                                 i_result.saturated);
                end else begin
                    want = expected_results.pop_front();
                    if (want.result_value !== i_result.result_value ||
                        want.saturated !== i_result.saturated) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: expected value %0d sat %0b, got %0d sat %0b",
                                     want.result_value, want.saturated,
                                     i_result.result_value, i_result.saturated);
                    end
                end
            end
            if (i_start && !i_busy)
                expected_results = {expected_results, predict_op(i_cmd)};
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LEARN_RATE: step_size = longint'(i_cfg_data);
                    CFG_FACTOR_REG: fac_decay = longint'(i_cfg_data);
                    CFG_BIAS_REG:   bias_decay = longint'(i_cfg_data);
                    default: ;
                endcase
            end
            o_pending = expected_results.size();
        end
    end

endmodule

// ----- sim/tb_pairwise_ranking_sgd_update_unit.sv -----
// Testbench top of the pairwise ranking update unit: request stimulus and verdict.
`timescale 1ns / 100ps

module tb_pairwise_ranking_sgd_update_unit;
    import prsu_pkg::*;

    localparam logic [1:0] SEL_NONE = 2'd3;   // select code with no weight behind it
    localparam int POOL_N = 8;
    localparam int PHASE_ITEMS = 114;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [1:0]       sel;
        logic [IDX_W-1:0] ent;
        logic [FI_W-1:0]  fi;
    } t_cell;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_cmd              i_cmd;
    logic              o_done;
    t_result           o_result;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;
    int                fail_count;
    int                pending;
    int                cycle_count;
    logic              calm;          // no random idling while set

    logic [IDX_W-1:0]  user_pool [POOL_N];
    logic [IDX_W-1:0]  item_pool [POOL_N];
    t_cell             written_cells[$];
    logic [CFG_W-1:0]  phase_cfg [5][3];

    pairwise_ranking_sgd_update_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_cmd(i_cmd),
        .o_done(o_done), .o_result(o_result), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    prsu_result_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy), .i_cmd(i_cmd),
        .i_done(o_done), .i_result(o_result), .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Stop a hung run.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Small Q8.24 value, mostly; sometimes the full range or an extreme.
    function automatic logic [W_BITS-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 70) return W_BITS'($urandom_range(32'h0400_0000) - 32'h0200_0000);
        if (r < 85) return $urandom;
        if (r < 92) return WMAX;
        return WMIN;
    endfunction

    // Fill every field with noise; the op builders override what matters.
    function automatic t_cmd noise_cmd();
        t_cmd c;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        c = raw[$bits(t_cmd)-1:0];
        return c;
    endfunction

    function automatic t_cmd train_cmd(input logic [IDX_W-1:0] it, input logic [IDX_W-1:0] pu,
                                       input logic [IDX_W-1:0] nu);
        t_cmd c;
        c = noise_cmd();
        c.op = OP_TRAIN;
        c.item_index = it;
        c.pos_user_index = pu;
        c.neg_user_index = nu;
        return c;
    endfunction

    function automatic t_cmd cell_cmd(input logic [1:0] op, input t_cell cl,
                                      input logic [W_BITS-1:0] v);
        t_cmd c;
        c = noise_cmd();
        c.op = op;
        c.weight_select = cl.sel;
        c.entry_index = cl.ent;
        c.factor_index = cl.fi;
        c.weight_value = v;
        return c;
    endfunction

    // Hold the request until the unit takes it; start stays high for the next one.
    task automatic issue_request(input t_cmd c);
        logic free;
        t_cell cl;
        while (!calm && $urandom_range(99) < 35) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        if (c.op == OP_LOAD && c.weight_select != SEL_NONE) begin
            cl = {c.weight_select, c.entry_index, c.factor_index};
            written_cells = {written_cells, cl};
        end
        do begin
            @(negedge i_clk);
            free = !busy;
            @(posedge i_clk);
        end while (!free);
    endtask

    task automatic load_cell(input logic [1:0] sel, input logic [IDX_W-1:0] ent,
                             input logic [FI_W-1:0] fi, input logic [W_BITS-1:0] v);
        issue_request(cell_cmd(OP_LOAD, {sel, ent, fi}, v));
    endtask

    task automatic drain_requests();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        logic rdy;
        while ($urandom_range(99) < 35) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do begin
            @(negedge i_clk);
            rdy = o_cfg_ready;
            @(posedge i_clk);
        end while (!rdy);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_request();
        int r;
        t_cmd c;
        t_cell cl;
        r = $urandom_range(99);
        if (r < 40) begin
            c = train_cmd(item_pool[$urandom_range(POOL_N-1)],
                          user_pool[$urandom_range(POOL_N-1)],
                          user_pool[$urandom_range(POOL_N-1)]);
        end else if (r < 55) begin
            c = train_cmd(item_pool[$urandom_range(POOL_N-1)],
                          user_pool[$urandom_range(POOL_N-1)], IDX_W'($urandom));
            c.op = OP_PREDICT;
        end else if (r < 75) begin
            if ($urandom_range(1)) begin
                cl = written_cells[$urandom_range(written_cells.size()-1)];
            end else begin
                cl.sel = 2'($urandom_range(2));
                cl.ent = IDX_W'($urandom);
                cl.fi = FI_W'($urandom);
            end
            c = cell_cmd(OP_LOAD, cl, pick_value());
        end else if (r < 92) begin
            c = cell_cmd(OP_READ, written_cells[$urandom_range(written_cells.size()-1)],
                         $urandom);
        end else begin
            c = noise_cmd();
            c.op = $urandom_range(1) ? OP_LOAD : OP_READ;
            c.weight_select = SEL_NONE;
        end
        issue_request(c);
    endtask

    initial begin
        start = 1'b0;
        i_cmd = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_LEARN_RATE;
        i_cfg_data = '0;
        calm = 1'b0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Working set: the index extremes, alternating bit patterns, random rows.
        user_pool = '{10'd0, 10'd1023, 10'h155, 10'h2aa, 10'd0, 10'd0, 10'd0, 10'd0};
        item_pool = '{10'd0, 10'd1023, 10'h2aa, 10'h155, 10'd0, 10'd0, 10'd0, 10'd0};
        for (int i = 4; i < POOL_N; i++) begin
            user_pool[i] = IDX_W'($urandom);
            item_pool[i] = IDX_W'($urandom);
        end
        phase_cfg = '{'{LEARN_RATE_RST, FACTOR_REG_RST, BIAS_REG_RST},
                      '{25'd0, 25'd0, 25'd0},
                      '{25'd16777216, 25'd16777216, 25'd16777216},
                      '{25'h1ffffff, 25'h1ffffff, 25'h1ffffff},
                      '{25'd0, 25'd0, 25'd0}};
        for (int k = 0; k < 3; k++) phase_cfg[4][k] = CFG_W'($urandom_range(25'h1ffffff));

        // Load every weight that train and predict touch in the working set.
        for (int i = 0; i < POOL_N; i++) begin
            load_cell(SEL_BIAS, user_pool[i], FI_W'($urandom),
                      W_BITS'($urandom_range(32'h0400_0000) - 32'h0200_0000));
            for (int f = 0; f < DEF_FACTORS; f++) begin
                load_cell(SEL_UFAC, user_pool[i], FI_W'(f),
                          W_BITS'($urandom_range(32'h0200_0000) - 32'h0100_0000));
                load_cell(SEL_IFAC, item_pool[i], FI_W'(f),
                          W_BITS'($urandom_range(32'h0200_0000) - 32'h0100_0000));
            end
        end

        // Directed: value extremes round-trip, unknown select, same user, predict.
        load_cell(SEL_BIAS, 10'd77, 4'd0, WMAX);
        load_cell(SEL_UFAC, 10'd1023, 4'd15, WMIN);
        load_cell(SEL_IFAC, 10'd0, 4'd15, 32'hffffffff);
        issue_request(cell_cmd(OP_READ, {SEL_BIAS, 10'd77, 4'd0}, '0));
        issue_request(cell_cmd(OP_READ, {SEL_UFAC, 10'd1023, 4'd15}, '0));
        issue_request(cell_cmd(OP_READ, {SEL_IFAC, 10'd0, 4'd15}, '0));
        issue_request(cell_cmd(OP_LOAD, {SEL_NONE, 10'd5, 4'd5}, WMAX));
        issue_request(cell_cmd(OP_READ, {SEL_NONE, 10'd5, 4'd5}, '0));
        issue_request(train_cmd(item_pool[0], user_pool[0], user_pool[1]));
        issue_request(train_cmd(item_pool[1], user_pool[2], user_pool[2]));
        issue_request(train_cmd(item_pool[1], user_pool[1], user_pool[0]));
        begin
            t_cmd c;
            c = train_cmd(item_pool[1], user_pool[1], 10'd0);
            c.op = OP_PREDICT;
            issue_request(c);
        end
        // Drive two biases to the extremes to force the clamps, then set them back to moderate values.
        load_cell(SEL_BIAS, user_pool[3], 4'd0, WMAX);
        load_cell(SEL_BIAS, user_pool[2], 4'd0, WMIN);
        issue_request(train_cmd(item_pool[2], user_pool[3], user_pool[2]));
        load_cell(SEL_BIAS, user_pool[3], 4'd0, 32'h0100_0000);
        load_cell(SEL_BIAS, user_pool[2], 4'd0, 32'hff00_0000);

        // Random phases; registers change only while the unit is idle.
        for (int p = 0; p < 5; p++) begin
            drain_requests();
            write_register(CFG_LEARN_RATE, phase_cfg[p][0]);
            write_register(CFG_FACTOR_REG, phase_cfg[p][1]);
            write_register(CFG_BIAS_REG, phase_cfg[p][2]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                calm = (p == 2) && (n < 80);
                random_request();
            end
        end
        calm = 1'b0;

        // Drain, then wait for anything stray before the verdict.
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
